[rtl/core/nsva_pkg.sv]
// Shared types and constants for the nearest-seed assignment block.
`default_nettype none

package nsva_pkg;

   // Function codes of an incoming item.
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   // Fixed widths of the interface fields.
   localparam int FIELD_BITS    = 16;
   localparam int IDX_OUT_BITS  = 6;
   localparam int DIST_OUT_BITS = 34;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [FIELD_BITS-1:0] pos_x;
      logic signed [FIELD_BITS-1:0] pos_y;
      logic signed [FIELD_BITS-1:0] pos_z;
      logic [FIELD_BITS-1:0]        liquid_level;
      logic [FIELD_BITS-1:0]        preset_level;
   } req_type;

   typedef struct packed {
      logic                     assigned;
      logic [IDX_OUT_BITS-1:0]  seed_index;
      logic [DIST_OUT_BITS-1:0] min_dist_sq;
   } rsp_type;

   // Operation after classification; an unqualified query needs no scan.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_REJECT = 2'd3
   } op_type;

   typedef struct packed {
      op_type                       op;
      logic signed [FIELD_BITS-1:0] x;
      logic signed [FIELD_BITS-1:0] y;
      logic signed [FIELD_BITS-1:0] z;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_slot_type;

endpackage

`default_nettype wire

[rtl/core/nsva_front.sv]
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none

module nsva_front #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire nsva_pkg::req_type     req_data,
   output nsva_pkg::cmd_slot_type     slot,
   input  wire logic                  pop
);

   localparam int CW    = (COORD_BITS < nsva_pkg::FIELD_BITS) ? COORD_BITS
                                                               : nsva_pkg::FIELD_BITS;
   localparam int SHIFT = nsva_pkg::FIELD_BITS - CW;

   nsva_pkg::cmd_type cmd_in;
   logic              keep;
   logic              push;
   logic signed [nsva_pkg::FIELD_BITS-1:0] sx;
   logic signed [nsva_pkg::FIELD_BITS-1:0] sy;
   logic signed [nsva_pkg::FIELD_BITS-1:0] sz;

   nsva_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   // Only the low coordinate bits count; they are sign-extended back to the field width.
   always_comb begin
      sx = req_data.pos_x <<< SHIFT;
      sy = req_data.pos_y <<< SHIFT;
      sz = req_data.pos_z <<< SHIFT;
      cmd_in.x = sx >>> SHIFT;
      cmd_in.y = sy >>> SHIFT;
      cmd_in.z = sz >>> SHIFT;
      keep = 1'b1;
      unique case (req_data.func)
         nsva_pkg::FUNC_CLEAR: cmd_in.op = nsva_pkg::OP_CLEAR;
         nsva_pkg::FUNC_LOAD:  cmd_in.op = nsva_pkg::OP_LOAD;
         nsva_pkg::FUNC_QUERY: begin
            // Liquid must reach 1.0 and the preset value must stay below it.
            if (req_data.liquid_level[nsva_pkg::FIELD_BITS-1] &&
                !req_data.preset_level[nsva_pkg::FIELD_BITS-1]) begin
               cmd_in.op = nsva_pkg::OP_QUERY;
            end else begin
               cmd_in.op = nsva_pkg::OP_REJECT;
            end
         end
         default: begin
            cmd_in.op = nsva_pkg::OP_CLEAR;
            keep      = 1'b0;
         end
      endcase
   end

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy && keep;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign slot.valid = (cnt_ff != 2'd0);
   assign slot.cmd   = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[rtl/core/nsva_back.sv]
// Back end: seed table, nearest-seed scan pipeline and result register.
`default_nettype none

module nsva_back #(
   parameter int MAX_SEEDS  = 64,
   parameter int COORD_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nsva_pkg::cmd_slot_type slot,
   output logic                        pop,
   output logic                        rsp_valid,
   output nsva_pkg::rsp_type           rsp_data
);

   localparam int CW   = (COORD_BITS < nsva_pkg::FIELD_BITS) ? COORD_BITS
                                                              : nsva_pkg::FIELD_BITS;
   localparam int IW   = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNTW = $clog2(MAX_SEEDS + 1);
   localparam int SW   = 2 * CW;
   localparam int DW   = 2 * CW + 2;
   localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_SEEDS);

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } seed_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [IW-1:0]   issue_ff, issue_in;
   logic            wr_en;
   logic            rd_en;
   logic            start_scan;
   logic            emit_reject;
   logic            issue_last;
   seed_type        wr_seed;

   seed_type             mem [MAX_SEEDS];
   seed_type             rd_ff;
   logic signed [CW-1:0] qx_ff, qy_ff, qz_ff;

   logic          p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic          p1_last_ff, p2_last_ff, p3_last_ff, p4_last_ff;
   logic [IW-1:0] p1_idx_ff, p2_idx_ff, p3_idx_ff, p4_idx_ff;

   logic signed [CW:0] dx, dy, dz;
   logic signed [CW:0] ndx, ndy, ndz;
   logic [CW-1:0]      adx_in, ady_in, adz_in;
   logic [CW-1:0]      adx_ff, ady_ff, adz_ff;
   logic [SW-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [DW-1:0]      sum_ff;

   logic [DW-1:0] best_ff, best_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic          take;

   logic              rsp_valid_ff, rsp_valid_in;
   nsva_pkg::rsp_type rsp_ff, rsp_in;

   // Command sequencer.
   always_comb begin
      pop         = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      start_scan  = 1'b0;
      emit_reject = 1'b0;
      issue_last  = 1'b0;
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (slot.valid) begin
               pop = 1'b1;
               unique case (slot.cmd.op)
                  nsva_pkg::OP_CLEAR: count_in = '0;
                  nsva_pkg::OP_LOAD: begin
                     // A load into a full table is dropped.
                     if (count_ff != MAX_CNT) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNTW'(1);
                     end
                  end
                  nsva_pkg::OP_QUERY: begin
                     if (count_ff == '0) begin
                        emit_reject = 1'b1;
                     end else begin
                        start_scan = 1'b1;
                        issue_in   = '0;
                        state_in   = ST_SCAN;
                     end
                  end
                  nsva_pkg::OP_REJECT: emit_reject = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            issue_last = ((CNTW'(issue_ff) + CNTW'(1)) == count_ff);
            if (issue_last) begin
               state_in = ST_WAIT;
            end else begin
               issue_in = issue_ff + IW'(1);
            end
         end
         ST_WAIT: begin
            if (p4_valid_ff && p4_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign wr_seed.x = slot.cmd.x[CW-1:0];
   assign wr_seed.y = slot.cmd.y[CW-1:0];
   assign wr_seed.z = slot.cmd.z[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      if (start_scan) begin
         qx_ff <= wr_seed.x;
         qy_ff <= wr_seed.y;
         qz_ff <= wr_seed.z;
      end
   end

   // Seed table: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= wr_seed;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[issue_ff];
      end
   end

   // Absolute coordinate differences always fit in CW unsigned bits.
   always_comb begin
      dx     = {qx_ff[CW-1], qx_ff} - {rd_ff.x[CW-1], rd_ff.x};
      dy     = {qy_ff[CW-1], qy_ff} - {rd_ff.y[CW-1], rd_ff.y};
      dz     = {qz_ff[CW-1], qz_ff} - {rd_ff.z[CW-1], rd_ff.z};
      ndx    = -dx;
      ndy    = -dy;
      ndz    = -dz;
      adx_in = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
      ady_in = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
      adz_in = dz[CW] ? ndz[CW-1:0] : dz[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= rd_en;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_last_ff <= issue_last;
      p1_idx_ff  <= issue_ff;
      p2_last_ff <= p1_last_ff;
      p2_idx_ff  <= p1_idx_ff;
      p3_last_ff <= p2_last_ff;
      p3_idx_ff  <= p2_idx_ff;
      p4_last_ff <= p3_last_ff;
      p4_idx_ff  <= p3_idx_ff;
      adx_ff     <= adx_in;
      ady_ff     <= ady_in;
      adz_ff     <= adz_in;
      sqx_ff     <= SW'(adx_ff) * SW'(adx_ff);
      sqy_ff     <= SW'(ady_ff) * SW'(ady_ff);
      sqz_ff     <= SW'(adz_ff) * SW'(adz_ff);
      sum_ff     <= DW'(sqx_ff) + DW'(sqy_ff) + DW'(sqz_ff);
   end

   // The first seed of a scan always wins; later ones only on a strictly smaller distance.
   always_comb begin
      take        = (p4_idx_ff == '0) || (sum_ff < best_ff);
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (p4_valid_ff && take) begin
         best_in     = sum_ff;
         best_idx_in = p4_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   always_comb begin
      rsp_valid_in = emit_reject || (p4_valid_ff && p4_last_ff);
      if (emit_reject) begin
         rsp_in = '0;
      end else begin
         rsp_in.assigned    = 1'b1;
         rsp_in.seed_index  = nsva_pkg::IDX_OUT_BITS'(best_idx_in);
         rsp_in.min_dist_sq = nsva_pkg::DIST_OUT_BITS'(best_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/nearest_seed_voronoi_assign_top.sv]
// Nearest-seed assignment: a queued front end feeding a one-seed-per-cycle scan engine.
// A qualified query runs from the queue through the scan state, the table read register and
// the difference, square, sum and result registers; an unqualified query, or one against an
// empty table, goes straight to the result register. A query holds the scan engine and the
// single table read port until its last seed is summed; a two-entry queue sits in front.
// Reset clears the seed count, queue and pipeline; the seed table itself is left as it is.
`default_nettype none

module nearest_seed_voronoi_assign_top #(
   parameter int MAX_SEEDS  = 64,
   parameter int COORD_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire nsva_pkg::req_type req_data,
   output logic                   rsp_valid,
   output nsva_pkg::rsp_type      rsp_data
);

   nsva_pkg::cmd_slot_type slot;
   logic                   pop;

   nsva_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .slot     (slot),
      .pop      (pop)
   );

   nsva_back #(
      .MAX_SEEDS  (MAX_SEEDS),
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .slot      (slot),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
